>>> rtl/core/mccs_pkg.sv
// Package of the multicycle control sequencer: step numbers, instruction
// class codes, control bit positions and the small decode functions.
// Depends on nothing.
`default_nettype none

package mccs_pkg;

  // Control step numbers.
  localparam logic [3:0] STEP_FETCH     = 4'd1;
  localparam logic [3:0] STEP_PC_UPDATE = 4'd2;
  localparam logic [3:0] STEP_R_ALU     = 4'd3;
  localparam logic [3:0] STEP_I_ALU     = 4'd4;
  localparam logic [3:0] STEP_BR_TEST   = 4'd5;
  localparam logic [3:0] STEP_JUMP      = 4'd6;
  localparam logic [3:0] STEP_EADDR     = 4'd7;
  localparam logic [3:0] STEP_BR_TAKE   = 4'd8;
  localparam logic [3:0] STEP_ST_DATA   = 4'd9;
  localparam logic [3:0] STEP_LD_MEM    = 4'd10;
  localparam logic [3:0] STEP_ST_MEM    = 4'd11;
  localparam logic [3:0] STEP_LD_MOVE   = 4'd12;
  localparam logic [3:0] STEP_WRITEBACK = 4'd13;

  // Instruction kinds referred to by name.
  localparam logic [4:0] KIND_AND  = 5'd1;
  localparam logic [4:0] KIND_OR   = 5'd2;
  localparam logic [4:0] KIND_SLL  = 5'd3;
  localparam logic [4:0] KIND_SRL  = 5'd4;
  localparam logic [4:0] KIND_SUB  = 5'd5;
  localparam logic [4:0] KIND_ORI  = 5'd7;
  localparam logic [4:0] KIND_LB   = 5'd8;
  localparam logic [4:0] KIND_LH   = 5'd9;
  localparam logic [4:0] KIND_LW   = 5'd10;
  localparam logic [4:0] KIND_SB   = 5'd11;
  localparam logic [4:0] KIND_SH   = 5'd12;
  localparam logic [4:0] KIND_SW   = 5'd13;
  localparam logic [4:0] KIND_BEQZ = 5'd14;
  localparam logic [4:0] KIND_BNEZ = 5'd15;
  localparam logic [4:0] KIND_J    = 5'd16;

  // Instruction classes.
  localparam logic [2:0] CLS_R     = 3'd0;
  localparam logic [2:0] CLS_I     = 3'd1;
  localparam logic [2:0] CLS_LOAD  = 3'd2;
  localparam logic [2:0] CLS_STORE = 3'd3;
  localparam logic [2:0] CLS_BR    = 3'd4;
  localparam logic [2:0] CLS_JUMP  = 3'd5;
  localparam logic [2:0] CLS_NONE  = 3'd6;

  // Load enable bits.
  localparam logic [7:0] LD_A   = 8'h01;
  localparam logic [7:0] LD_B   = 8'h02;
  localparam logic [7:0] LD_C   = 8'h04;
  localparam logic [7:0] LD_PC  = 8'h08;
  localparam logic [7:0] LD_IR  = 8'h10;
  localparam logic [7:0] LD_MAR = 8'h20;
  localparam logic [7:0] LD_MDR = 8'h40;
  localparam logic [7:0] LD_RF  = 8'h80;

  // Drive enable bits.
  localparam logic [4:0] DR_A      = 5'h01;
  localparam logic [4:0] DR_B      = 5'h02;
  localparam logic [4:0] DR_PC_S1  = 5'h04;
  localparam logic [4:0] DR_IR_S2  = 5'h08;
  localparam logic [4:0] DR_MDR_S2 = 5'h10;

  // S2 operand select codes.
  localparam logic [2:0] S2_REG   = 3'd0;
  localparam logic [2:0] S2_MDR   = 3'd1;
  localparam logic [2:0] S2_IMM16 = 3'd3;
  localparam logic [2:0] S2_IMM26 = 3'd5;
  localparam logic [2:0] S2_FOUR  = 3'd7;

  // ALU function codes.
  localparam logic [3:0] ALU_ADD  = 4'd0;
  localparam logic [3:0] ALU_SUB  = 4'd1;
  localparam logic [3:0] ALU_PASS = 4'd3;
  localparam logic [3:0] ALU_AND  = 4'd4;
  localparam logic [3:0] ALU_OR   = 4'd5;
  localparam logic [3:0] ALU_SLL  = 4'd8;
  localparam logic [3:0] ALU_SRL  = 4'd10;

  // Memory access sizes.
  localparam logic [1:0] SIZE_WORD = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_BYTE = 2'd2;

  // One control word, as it leaves the block.
  typedef struct packed {
    logic       dest_select;
    logic [3:0] alu_operation;
    logic [2:0] s2_operation;
    logic       address_select;
    logic [1:0] mem_size;
    logic       mem_write;
    logic       mem_read;
    logic [4:0] drive_enables;
    logic [7:0] load_enables;
    logic [3:0] step;
  } ctrl_word_t;

  function automatic logic [2:0] kind_class(input logic [4:0] kind);
    logic [2:0] cls;
    if (kind <= KIND_SUB)       cls = CLS_R;
    else if (kind <= KIND_ORI)  cls = CLS_I;
    else if (kind <= KIND_LW)   cls = CLS_LOAD;
    else if (kind <= KIND_SW)   cls = CLS_STORE;
    else if (kind <= KIND_BNEZ) cls = CLS_BR;
    else if (kind == KIND_J)    cls = CLS_JUMP;
    else                        cls = CLS_NONE;
    return cls;
  endfunction

  function automatic logic [3:0] alu_code(input logic [4:0] kind);
    logic [3:0] op;
    case (kind)
      KIND_AND:          op = ALU_AND;
      KIND_OR, KIND_ORI: op = ALU_OR;
      KIND_SLL:          op = ALU_SLL;
      KIND_SRL:          op = ALU_SRL;
      KIND_SUB:          op = ALU_SUB;
      default:           op = ALU_ADD;
    endcase
    return op;
  endfunction

  function automatic logic [1:0] size_code(input logic [4:0] kind);
    logic [1:0] sz;
    case (kind)
      KIND_LB, KIND_SB: sz = SIZE_BYTE;
      KIND_LH, KIND_SH: sz = SIZE_HALF;
      default:          sz = SIZE_WORD;
    endcase
    return sz;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/multicycle_cpu_control_sequencer_top.sv
// Control sequencer of a multicycle processor: step register, control word
// decode and an output register. Depends on mccs_pkg.
`default_nettype none

// Usage
// Each beat on the slave side is one clock tick of the processor: it carries
// the kind of the instruction being executed and the value of its rs1
// register. For every accepted beat the block executes the control step it
// holds, sends that step's control word as one beat on the master side and
// moves to the next step, chosen by the instruction class (fetch, PC update,
// then the R-type, I-type, load, store, branch or jump path).
// The branch test step compares the low DATA_WIDTH bits (at most 32) of rs1
// with zero: beqz branches on zero, bnez on non-zero.
// The control word of an accepted input beat is on the master side in the
// cycle after. A new beat can be taken in every cycle while the receiver
// keeps up: the decode is a single layer of logic between the step register
// and the output register, so the throughput is one beat per cycle.
// When the receiver stalls, the control word waits in the output register and
// s_axis_tready drops only while that register is full and not being taken.
// Reset puts the sequencer at instruction fetch and empties the output
// register. Unused step numbers behave as fetch.
module multicycle_cpu_control_sequencer_top #(
  parameter int DATA_WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] instr_kind, [36:5] rs1_value, [39:37] zero
  input  wire  [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [3:0] step, [11:4] load_enables, [16:12] drive_enables, [17] mem_read,
  // [18] mem_write, [20:19] mem_size, [21] address_select,
  // [24:22] s2_operation, [28:25] alu_operation, [29] dest_select, [31:30] zero
  output logic [31:0] m_axis_tdata
);

  // Only the low DATA_WIDTH bits (at most 32) of the 32-bit register value are tested.
  localparam int TestWidth = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

  logic [3:0]             current_step;
  logic [3:0]             current_step_next;
  mccs_pkg::ctrl_word_t   ctrl;
  mccs_pkg::ctrl_word_t   ctrl_next;
  logic                   in_fire;
  logic [4:0]             instr_kind;
  logic [31:0]            rs1_value;
  logic [2:0]             cls;
  logic [3:0]             st;
  logic                   zero_flag;

  assign instr_kind    = s_axis_tdata[4:0];
  assign rs1_value     = s_axis_tdata[36:5];
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {2'b00, ctrl};

  assign cls       = mccs_pkg::kind_class(instr_kind);
  assign zero_flag = (rs1_value[TestWidth-1:0] == '0);
  // Steps that do not exist behave as fetch.
  assign st = (current_step == 4'd0 || current_step > mccs_pkg::STEP_WRITEBACK) ?
              mccs_pkg::STEP_FETCH : current_step;

  always_comb begin
    ctrl_next         = '0;
    ctrl_next.step    = st;
    current_step_next = mccs_pkg::STEP_FETCH;
    case (st)
      mccs_pkg::STEP_FETCH: begin
        ctrl_next.mem_read     = 1'b1;
        ctrl_next.load_enables = mccs_pkg::LD_IR;
        current_step_next      = mccs_pkg::STEP_PC_UPDATE;
      end
      mccs_pkg::STEP_PC_UPDATE: begin
        ctrl_next.load_enables  = mccs_pkg::LD_A | mccs_pkg::LD_B | mccs_pkg::LD_PC;
        ctrl_next.drive_enables = mccs_pkg::DR_PC_S1;
        ctrl_next.s2_operation  = mccs_pkg::S2_FOUR;
        case (cls)
          mccs_pkg::CLS_R:     current_step_next = mccs_pkg::STEP_R_ALU;
          mccs_pkg::CLS_I:     current_step_next = mccs_pkg::STEP_I_ALU;
          mccs_pkg::CLS_LOAD:  current_step_next = mccs_pkg::STEP_EADDR;
          mccs_pkg::CLS_STORE: current_step_next = mccs_pkg::STEP_EADDR;
          mccs_pkg::CLS_BR:    current_step_next = mccs_pkg::STEP_BR_TEST;
          mccs_pkg::CLS_JUMP:  current_step_next = mccs_pkg::STEP_JUMP;
          default:             current_step_next = mccs_pkg::STEP_FETCH;
        endcase
      end
      mccs_pkg::STEP_R_ALU: begin
        ctrl_next.drive_enables = mccs_pkg::DR_A | mccs_pkg::DR_B;
        ctrl_next.load_enables  = mccs_pkg::LD_C;
        ctrl_next.s2_operation  = mccs_pkg::S2_REG;
        ctrl_next.alu_operation = mccs_pkg::alu_code(instr_kind);
        if (cls == mccs_pkg::CLS_R) current_step_next = mccs_pkg::STEP_WRITEBACK;
      end
      mccs_pkg::STEP_I_ALU: begin
        ctrl_next.drive_enables = mccs_pkg::DR_A | mccs_pkg::DR_IR_S2;
        ctrl_next.load_enables  = mccs_pkg::LD_C;
        ctrl_next.s2_operation  = mccs_pkg::S2_IMM16;
        ctrl_next.alu_operation = mccs_pkg::alu_code(instr_kind);
        if (cls == mccs_pkg::CLS_I) current_step_next = mccs_pkg::STEP_WRITEBACK;
      end
      mccs_pkg::STEP_BR_TEST: begin
        if ((instr_kind == mccs_pkg::KIND_BEQZ && zero_flag) ||
            (instr_kind == mccs_pkg::KIND_BNEZ && !zero_flag)) begin
          current_step_next = mccs_pkg::STEP_BR_TAKE;
        end
      end
      mccs_pkg::STEP_JUMP: begin
        ctrl_next.drive_enables = mccs_pkg::DR_PC_S1 | mccs_pkg::DR_IR_S2;
        ctrl_next.load_enables  = mccs_pkg::LD_PC;
        ctrl_next.s2_operation  = mccs_pkg::S2_IMM26;
      end
      mccs_pkg::STEP_EADDR: begin
        ctrl_next.load_enables  = mccs_pkg::LD_MAR;
        ctrl_next.drive_enables = mccs_pkg::DR_A | mccs_pkg::DR_IR_S2;
        ctrl_next.s2_operation  = mccs_pkg::S2_IMM16;
        if (cls == mccs_pkg::CLS_LOAD) begin
          current_step_next = mccs_pkg::STEP_LD_MEM;
        end else if (cls == mccs_pkg::CLS_STORE) begin
          current_step_next = mccs_pkg::STEP_ST_DATA;
        end
      end
      mccs_pkg::STEP_BR_TAKE: begin
        ctrl_next.drive_enables = mccs_pkg::DR_PC_S1 | mccs_pkg::DR_IR_S2;
        ctrl_next.load_enables  = mccs_pkg::LD_PC;
        ctrl_next.s2_operation  = mccs_pkg::S2_IMM16;
      end
      mccs_pkg::STEP_ST_DATA: begin
        ctrl_next.drive_enables = mccs_pkg::DR_B;
        ctrl_next.load_enables  = mccs_pkg::LD_MDR;
        ctrl_next.alu_operation = mccs_pkg::ALU_PASS;
        ctrl_next.s2_operation  = mccs_pkg::S2_REG;
        if (cls == mccs_pkg::CLS_STORE) current_step_next = mccs_pkg::STEP_ST_MEM;
      end
      mccs_pkg::STEP_LD_MEM: begin
        ctrl_next.address_select = 1'b1;
        ctrl_next.mem_read       = 1'b1;
        ctrl_next.load_enables   = mccs_pkg::LD_MDR;
        ctrl_next.mem_size       = mccs_pkg::size_code(instr_kind);
        if (cls == mccs_pkg::CLS_LOAD) current_step_next = mccs_pkg::STEP_LD_MOVE;
      end
      mccs_pkg::STEP_ST_MEM: begin
        ctrl_next.address_select = 1'b1;
        ctrl_next.mem_write      = 1'b1;
        ctrl_next.mem_size       = mccs_pkg::size_code(instr_kind);
      end
      mccs_pkg::STEP_LD_MOVE: begin
        ctrl_next.drive_enables = mccs_pkg::DR_MDR_S2;
        ctrl_next.load_enables  = mccs_pkg::LD_C;
        ctrl_next.alu_operation = mccs_pkg::ALU_PASS;
        ctrl_next.s2_operation  = mccs_pkg::S2_MDR;
        if (cls == mccs_pkg::CLS_LOAD) current_step_next = mccs_pkg::STEP_WRITEBACK;
      end
      default: begin
        // Write-back: the destination field depends on the instruction class.
        ctrl_next.load_enables = mccs_pkg::LD_RF;
        ctrl_next.dest_select  = (cls == mccs_pkg::CLS_R);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_step  <= mccs_pkg::STEP_FETCH;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_fire) begin
        current_step  <= current_step_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ctrl <= ctrl_next;
    end
  end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the multicycle CPU control sequencer: directed
// table, then random instruction streams checked against a behavioural
// predictor. Depends on mccs_pkg and multicycle_cpu_control_sequencer_top.

module tb_top;
  import mccs_pkg::*;

  localparam int DATA_W          = 32;
  localparam int RANDOM_ITEMS    = 800;
  localparam int MAX_IDLE        = 6;
  localparam int HOLD_OFF_AT     = 200;   // receiver beat count at which it holds off
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int TAIL_CYCLES     = 8;

  // Kinds that the package does not name, and the largest kind the field holds.
  localparam logic [4:0] KIND_ADD     = 5'd0;
  localparam logic [4:0] KIND_ADDI    = 5'd6;
  localparam logic [4:0] KIND_TOP     = 5'd31;

  localparam logic [31:0] RS1_ZERO = 32'h0000_0000;
  localparam logic [31:0] RS1_ONES = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    IC_R, IC_I, IC_LOAD, IC_STORE, IC_BRANCH, IC_JUMP, IC_NONE
  } instr_class_e;

  // One row of the directed table. Where typed is set, want holds the
  // control word written out by hand; otherwise the predictor supplies it.
  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] rs1;
    logic        typed;
    ctrl_word_t  want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [31:0] m_axis_tdata;

  // Predictor state: the step the sequencer will execute next and its zero flag.
  logic [3:0]  seq_step = STEP_FETCH;
  logic        seq_zero = 1'b0;

  ctrl_word_t  ctrl_words_due[$];
  stim_row_t   directed_rows[$];
  int          error_count = 0;
  int          idle_cycles = 0;

  // Hand-written control words for the rows whose result is plain to see.
  ctrl_word_t  fetch_word;
  ctrl_word_t  br_test_word;

  multicycle_cpu_control_sequencer_top #(.DATA_WIDTH(DATA_W)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk = ~clk;

  // ------------------------------------------------------------------------
  // Predictor of the control word sequence.
  // ------------------------------------------------------------------------

  function automatic instr_class_e classify(input logic [4:0] kind);
    instr_class_e cls;
    if (kind <= KIND_SUB)       cls = IC_R;
    else if (kind <= KIND_ORI)  cls = IC_I;
    else if (kind <= KIND_LW)   cls = IC_LOAD;
    else if (kind <= KIND_SW)   cls = IC_STORE;
    else if (kind <= KIND_BNEZ) cls = IC_BRANCH;
    else if (kind == KIND_J)    cls = IC_JUMP;
    else                        cls = IC_NONE;
    return cls;
  endfunction

  // ALU function chosen by kind; any kind without its own case adds.
  function automatic logic [3:0] alu_for_kind(input logic [4:0] kind);
    logic [3:0] op;
    op = ALU_ADD;
    if (kind == KIND_AND) op = ALU_AND;
    if (kind == KIND_OR || kind == KIND_ORI) op = ALU_OR;
    if (kind == KIND_SLL) op = ALU_SLL;
    if (kind == KIND_SRL) op = ALU_SRL;
    if (kind == KIND_SUB) op = ALU_SUB;
    return op;
  endfunction

  function automatic logic [1:0] access_size(input logic [4:0] kind);
    logic [1:0] sz;
    sz = SIZE_WORD;
    if (kind == KIND_LB || kind == KIND_SB) sz = SIZE_BYTE;
    if (kind == KIND_LH || kind == KIND_SH) sz = SIZE_HALF;
    return sz;
  endfunction

  // Executes one control step on the predictor state and returns its word.
  // The successor always follows the kind given in this beat, so a kind that
  // changes part way through an instruction steers the path from then on.
  task automatic run_control_step(input logic [4:0] kind, input logic [31:0] rs1,
                                  output ctrl_word_t w);
    instr_class_e cls;
    logic [3:0]   cur;
    logic [3:0]   nxt;
    logic         taken;
    cls = classify(kind);
    cur = seq_step;
    if (cur == 4'd0 || cur > STEP_WRITEBACK) cur = STEP_FETCH;
    w = '0;
    w.step = cur;
    nxt = STEP_FETCH;
    case (cur)
      STEP_PC_UPDATE: begin
        w.load_enables  = LD_A | LD_B | LD_PC;
        w.drive_enables = DR_PC_S1;
        w.s2_operation  = S2_FOUR;
        case (cls)
          IC_R:               nxt = STEP_R_ALU;
          IC_I:               nxt = STEP_I_ALU;
          IC_LOAD, IC_STORE:  nxt = STEP_EADDR;
          IC_BRANCH:          nxt = STEP_BR_TEST;
          IC_JUMP:            nxt = STEP_JUMP;
          default:            nxt = STEP_FETCH;
        endcase
      end
      STEP_R_ALU: begin
        w.drive_enables = DR_A | DR_B;
        w.load_enables  = LD_C;
        w.s2_operation  = S2_REG;
        w.alu_operation = alu_for_kind(kind);
        if (cls == IC_R) nxt = STEP_WRITEBACK;
      end
      STEP_I_ALU: begin
        w.drive_enables = DR_A | DR_IR_S2;
        w.load_enables  = LD_C;
        w.s2_operation  = S2_IMM16;
        w.alu_operation = alu_for_kind(kind);
        if (cls == IC_I) nxt = STEP_WRITEBACK;
      end
      STEP_BR_TEST: begin
        seq_zero = (rs1[DATA_W-1:0] == '0);
        taken = (kind == KIND_BEQZ && seq_zero) || (kind == KIND_BNEZ && !seq_zero);
        if (taken) nxt = STEP_BR_TAKE;
      end
      STEP_JUMP: begin
        w.drive_enables = DR_PC_S1 | DR_IR_S2;
        w.load_enables  = LD_PC;
        w.s2_operation  = S2_IMM26;
      end
      STEP_EADDR: begin
        w.load_enables  = LD_MAR;
        w.drive_enables = DR_A | DR_IR_S2;
        w.s2_operation  = S2_IMM16;
        if (cls == IC_LOAD) nxt = STEP_LD_MEM;
        else if (cls == IC_STORE) nxt = STEP_ST_DATA;
      end
      STEP_BR_TAKE: begin
        w.drive_enables = DR_PC_S1 | DR_IR_S2;
        w.load_enables  = LD_PC;
        w.s2_operation  = S2_IMM16;
      end
      STEP_ST_DATA: begin
        w.drive_enables = DR_B;
        w.load_enables  = LD_MDR;
        w.alu_operation = ALU_PASS;
        w.s2_operation  = S2_REG;
        if (cls == IC_STORE) nxt = STEP_ST_MEM;
      end
      STEP_LD_MEM: begin
        w.address_select = 1'b1;
        w.mem_read       = 1'b1;
        w.load_enables   = LD_MDR;
        w.mem_size       = access_size(kind);
        if (cls == IC_LOAD) nxt = STEP_LD_MOVE;
      end
      STEP_ST_MEM: begin
        w.address_select = 1'b1;
        w.mem_write      = 1'b1;
        w.mem_size       = access_size(kind);
      end
      STEP_LD_MOVE: begin
        w.drive_enables = DR_MDR_S2;
        w.load_enables  = LD_C;
        w.alu_operation = ALU_PASS;
        w.s2_operation  = S2_MDR;
        if (cls == IC_LOAD) nxt = STEP_WRITEBACK;
      end
      STEP_WRITEBACK: begin
        w.load_enables = LD_RF;
        w.dest_select  = (cls == IC_R);
      end
      default: begin
        w.mem_read     = 1'b1;
        w.load_enables = LD_IR;
        nxt = STEP_PC_UPDATE;
      end
    endcase
    seq_step = nxt;
  endtask

  // ------------------------------------------------------------------------
  // Checking.
  // ------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Field-by-field comparison of a control word beat with the oldest one due.
  always @(posedge clk) begin
    ctrl_word_t got;
    ctrl_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = ctrl_word_t'(m_axis_tdata[29:0]);
      if (ctrl_words_due.size() == 0) begin
        report_mismatch("control word with none due, step", int'(got.step), 0);
      end else begin
        want = ctrl_words_due.pop_front();
        if (got.step !== want.step)
          report_mismatch("step", int'(got.step), int'(want.step));
        if (got.load_enables !== want.load_enables)
          report_mismatch("load_enables", int'(got.load_enables),
                          int'(want.load_enables));
        if (got.drive_enables !== want.drive_enables)
          report_mismatch("drive_enables", int'(got.drive_enables),
                          int'(want.drive_enables));
        if (got.mem_read !== want.mem_read)
          report_mismatch("mem_read", int'(got.mem_read), int'(want.mem_read));
        if (got.mem_write !== want.mem_write)
          report_mismatch("mem_write", int'(got.mem_write), int'(want.mem_write));
        if (got.mem_size !== want.mem_size)
          report_mismatch("mem_size", int'(got.mem_size), int'(want.mem_size));
        if (got.address_select !== want.address_select)
          report_mismatch("address_select", int'(got.address_select),
                          int'(want.address_select));
        if (got.s2_operation !== want.s2_operation)
          report_mismatch("s2_operation", int'(got.s2_operation),
                          int'(want.s2_operation));
        if (got.alu_operation !== want.alu_operation)
          report_mismatch("alu_operation", int'(got.alu_operation),
                          int'(want.alu_operation));
        if (got.dest_select !== want.dest_select)
          report_mismatch("dest_select", int'(got.dest_select), int'(want.dest_select));
        if (m_axis_tdata[31:30] !== 2'b00)
          report_mismatch("padding bits", int'(m_axis_tdata[31:30]), 0);
      end
    end
  end

  // The watchdog ends a run in which neither side has moved a beat for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Sender side.
  // ------------------------------------------------------------------------

  int  tx_beats = 0;
  bit  tx_burst = 1'b0;

  // Offers one instruction beat after a random gap, waits for it to be taken
  // and then files the control word it must produce.
  task automatic send_beat(input logic [4:0] kind, input logic [31:0] rs1,
                           input logic typed, input ctrl_word_t typed_word);
    int         gap;
    ctrl_word_t w;
    if (tx_beats % 48 == 0) tx_burst = ($urandom_range(0, 3) == 0);
    gap = tx_burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, rs1, kind};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    run_control_step(kind, rs1, w);
    ctrl_words_due.push_back(typed ? typed_word : w);
    tx_beats++;
  endtask

  task automatic add_row(input logic [4:0] kind, input logic [31:0] rs1,
                         input logic typed, input ctrl_word_t want);
    stim_row_t row;
    row.kind  = kind;
    row.rs1   = rs1;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Random register value: zero and all ones are drawn often, since the
  // branch test step only cares whether the value is zero.
  function automatic logic [31:0] pick_rs1();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0:       v = RS1_ZERO;
      1:       v = RS1_ONES;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // ------------------------------------------------------------------------
  // Receiver side: random stalls, bursts without stalls, and one long hold-off
  // during which the sender keeps offering so that the output register fills
  // and the block has to drop s_axis_tready.
  // ------------------------------------------------------------------------

  initial begin
    int stall;
    int rx_beats;
    bit rx_burst;
    rx_beats = 0;
    rx_burst = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (rx_beats % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      stall = rx_burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (rx_beats == HOLD_OFF_AT) stall = HOLD_OFF_CYCLES;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      rx_beats++;
    end
  end

  // ------------------------------------------------------------------------
  // Main sequence: reset, directed table, random instruction streams, drain.
  // ------------------------------------------------------------------------

  initial begin
    ctrl_word_t  none;
    logic [4:0]  held_kind;
    logic [4:0]  kind;
    logic [31:0] rs1;

    none = '0;
    fetch_word = '0;
    fetch_word.step         = STEP_FETCH;
    fetch_word.load_enables = LD_IR;
    fetch_word.mem_read     = 1'b1;
    br_test_word = '0;
    br_test_word.step = STEP_BR_TEST;

    // The first beat after reset must be a fetch. A kind with no class is
    // then sent back to fetch straight from the PC update.
    add_row(KIND_TOP,  RS1_ONES, 1'b1, fetch_word);
    add_row(KIND_TOP,  RS1_ZERO, 1'b0, none);
    // Store path, with the kind switched to a byte store for the memory step.
    add_row(KIND_SW,   RS1_ONES, 1'b1, fetch_word);
    add_row(KIND_SW,   RS1_ZERO, 1'b0, none);
    add_row(KIND_SW,   RS1_ONES, 1'b0, none);
    add_row(KIND_SH,   RS1_ZERO, 1'b0, none);
    add_row(KIND_SB,   RS1_ONES, 1'b0, none);
    // Load path, changing width part way through.
    add_row(KIND_LB,   RS1_ZERO, 1'b1, fetch_word);
    add_row(KIND_LH,   RS1_ONES, 1'b0, none);
    add_row(KIND_LW,   RS1_ZERO, 1'b0, none);
    add_row(KIND_LH,   RS1_ONES, 1'b0, none);
    add_row(KIND_LB,   RS1_ZERO, 1'b0, none);
    add_row(KIND_LB,   RS1_ONES, 1'b0, none);
    // Branch if zero, taken on a zero register.
    add_row(KIND_BEQZ, RS1_ONES, 1'b1, fetch_word);
    add_row(KIND_BEQZ, RS1_ONES, 1'b0, none);
    add_row(KIND_BEQZ, RS1_ZERO, 1'b1, br_test_word);
    add_row(KIND_J,    RS1_ONES, 1'b0, none);
    // Branch if non-zero, taken on all ones; the jump kind is already set
    // while the branch still completes.
    add_row(KIND_BNEZ, RS1_ZERO, 1'b1, fetch_word);
    add_row(KIND_BNEZ, RS1_ZERO, 1'b0, none);
    add_row(KIND_BNEZ, RS1_ONES, 1'b1, br_test_word);
    add_row(KIND_J,    RS1_ZERO, 1'b0, none);
    // Jump, then an I-type whose kind becomes an R-type for the write-back.
    add_row(KIND_J,    RS1_ZERO, 1'b1, fetch_word);
    add_row(KIND_J,    RS1_ONES, 1'b0, none);
    add_row(KIND_J,    RS1_ZERO, 1'b0, none);
    add_row(KIND_ADDI, RS1_ONES, 1'b1, fetch_word);
    add_row(KIND_ORI,  RS1_ZERO, 1'b0, none);
    add_row(KIND_ORI,  RS1_ONES, 1'b0, none);
    add_row(KIND_ADD,  RS1_ZERO, 1'b0, none);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].kind, directed_rows[i].rs1,
                directed_rows[i].typed, directed_rows[i].want);

    // Random part. Mostly well-formed instructions: a kind is chosen at each
    // fetch and held until the sequence returns there, so every path runs to
    // its end. A few beats carry any kind the field can hold, which breaks
    // sequences part way and exercises kinds with no class.
    held_kind = KIND_ADD;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (seq_step == STEP_FETCH) held_kind = 5'($urandom_range(0, KIND_J));
      kind = held_kind;
      if ($urandom_range(0, 99) < 8) kind = 5'($urandom_range(0, KIND_TOP));
      rs1 = pick_rs1();
      if (seq_step == STEP_BR_TEST && $urandom_range(0, 1) == 0) rs1 = RS1_ZERO;
      send_beat(kind, rs1, 1'b0, none);
    end
    s_axis_tvalid <= 1'b0;

    // Drain: every control word must have come out, then a short tail to
    // catch any stray beat.
    while (ctrl_words_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
